// File: hdl/jtpt_pkg.sv
// Shared types and constants for the joystick to pan/tilt command block.
// Used by the channel interfaces, the feature stage, the command sequencer and the checker.
// No dependencies.
package jtpt_pkg;

  localparam int XyW            = 16;
  localparam int DeadZoneW      = 15;
  localparam int SpeedW         = 3;
  localparam int ChanW          = 2;
  localparam int SqW            = 31;
  localparam int SpeedLevelsDef = 7;
  localparam int SpeedCapMax    = 7;

  localparam logic [DeadZoneW-1:0] DeadZoneRst = 15'd3277;

  localparam logic [ChanW-1:0] ChanStop  = 2'd1;
  localparam logic [ChanW-1:0] ChanStart = 2'd2;

  localparam logic [SpeedW-1:0] StopSpeed = 3'd1;

  typedef enum logic [2:0] {
    DIR_UP         = 3'd0,
    DIR_DOWN       = 3'd1,
    DIR_LEFT       = 3'd2,
    DIR_RIGHT      = 3'd3,
    DIR_UP_LEFT    = 3'd4,
    DIR_UP_RIGHT   = 3'd5,
    DIR_DOWN_LEFT  = 3'd6,
    DIR_DOWN_RIGHT = 3'd7
  } dir_t;

  // Per-item features handed from the feature stage to the sequencer.
  typedef struct packed {
    logic              centered;
    logic              xy_zero;
    logic              x_pos;
    logic              y_pos;
    logic [SqW-1:0]    xs;
    logic [SqW-1:0]    ys;
    logic [SpeedW-1:0] speed;
  } feat_t;

endpackage

// File: hdl/jtpt_if.sv
// Valid/ready channel interfaces: joystick words, command words, dead-zone writes.
// Depends on jtpt_pkg.
interface jtpt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [jtpt_pkg::XyW-1:0]     x_deflection;
  logic signed [jtpt_pkg::XyW-1:0]     y_deflection;

  modport source (output valid, x_deflection, y_deflection, input ready);
  modport sink (input valid, x_deflection, y_deflection, output ready);
endinterface

interface jtpt_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      direction;
  logic                            stop_flag;
  logic [jtpt_pkg::SpeedW-1:0]     speed;
  logic [jtpt_pkg::ChanW-1:0]      channel;
  logic                            last;

  modport source (output valid, direction, stop_flag, speed, channel, last, input ready);
  modport sink (input valid, direction, stop_flag, speed, channel, last, output ready);
endinterface

interface jtpt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [jtpt_pkg::DeadZoneW-1:0]     dead_zone;

  modport source (output valid, dead_zone, input ready);
  modport sink (input valid, dead_zone, output ready);
endinterface

// File: hdl/jtpt_calc.sv
// Feature stage: input register, magnitudes, squares, speed level, dead-zone test.
// Depends on jtpt_pkg and jtpt_if.
module jtpt_calc #(
  parameter int SPEED_LEVELS = jtpt_pkg::SpeedLevelsDef
) (
  input  logic                             clk,
  input  logic                             rst,
  jtpt_in_if.sink                          joy,
  input  logic [jtpt_pkg::DeadZoneW-1:0]   dead_zone,
  output logic                             feat_valid,
  input  logic                             feat_ready,
  output jtpt_pkg::feat_t                  feat
);

  localparam int MagW  = jtpt_pkg::XyW + 1;
  localparam int LvlW  = $clog2(SPEED_LEVELS + 1);
  localparam int ProdW = MagW + LvlW;
  localparam int Cap   = (SPEED_LEVELS < jtpt_pkg::SpeedCapMax) ? SPEED_LEVELS
                                                                  : jtpt_pkg::SpeedCapMax;

  logic                          in_valid;
  logic signed [jtpt_pkg::XyW-1:0] in_x;
  logic signed [jtpt_pkg::XyW-1:0] in_y;
  logic                          feat_load;
  logic [MagW-1:0]               xe, ye, ax, ay, mx;
  logic [2*MagW-1:0]             xsq, ysq;
  logic [ProdW-1:0]              prod;
  logic [ProdW-16:0]             lvl;
  jtpt_pkg::feat_t               feat_next;

  assign feat_load = in_valid && (!feat_valid || feat_ready);
  assign joy.ready = !in_valid || feat_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (joy.ready) begin
      in_valid <= joy.valid;
    end
    if (joy.ready && joy.valid) begin
      in_x <= joy.x_deflection;
      in_y <= joy.y_deflection;
    end
  end

  always_comb begin
    xe   = {in_x[jtpt_pkg::XyW-1], in_x};
    ye   = {in_y[jtpt_pkg::XyW-1], in_y};
    ax   = in_x[jtpt_pkg::XyW-1] ? (~xe + MagW'(1)) : xe;
    ay   = in_y[jtpt_pkg::XyW-1] ? (~ye + MagW'(1)) : ye;
    mx   = (ax > ay) ? ax : ay;
    xsq  = ax * ax;
    ysq  = ay * ay;
    prod = ProdW'(mx) * ProdW'(SPEED_LEVELS);
    lvl  = prod[ProdW-1:15];

    feat_next.centered = (ax < MagW'(dead_zone)) && (ay < MagW'(dead_zone));
    feat_next.xy_zero  = (in_x == '0) && (in_y == '0);
    feat_next.x_pos    = !in_x[jtpt_pkg::XyW-1] && (in_x != '0);
    feat_next.y_pos    = !in_y[jtpt_pkg::XyW-1] && (in_y != '0);
    feat_next.xs       = xsq[jtpt_pkg::SqW-1:0];
    feat_next.ys       = ysq[jtpt_pkg::SqW-1:0];
    // Floor the level, lift zero to one, clamp at the cap.
    if (lvl == '0) begin
      feat_next.speed = jtpt_pkg::SpeedW'(1);
    end else if (lvl > (ProdW-15)'(Cap)) begin
      feat_next.speed = jtpt_pkg::SpeedW'(Cap);
    end else begin
      feat_next.speed = jtpt_pkg::SpeedW'(lvl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feat_valid <= 1'b0;
    end else if (!feat_valid || feat_ready) begin
      feat_valid <= in_valid;
    end
    if (feat_load) begin
      feat <= feat_next;
    end
  end

endmodule

// File: hdl/jtpt_seq.sv
// Command sequencer: sector decision, motion state, stop/start word ordering, output register.
// Depends on jtpt_pkg and jtpt_if.
module jtpt_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             feat_valid,
  output logic             feat_ready,
  input  jtpt_pkg::feat_t  feat,
  jtpt_out_if.source       cmd
);

  logic                        motion_active;
  jtpt_pkg::dir_t              active_direction;
  logic                        stop_sent;
  logic                        can_load;
  logic                        load;
  logic                        load_stop;
  logic                        load_last;
  logic [jtpt_pkg::SqW:0]      tri_xs, tri_ys;
  jtpt_pkg::dir_t              sector;

  always_comb begin
    tri_xs = {feat.xs, 1'b0} + {1'b0, feat.xs};
    tri_ys = {feat.ys, 1'b0} + {1'b0, feat.ys};
    if (feat.xy_zero) begin
      sector = jtpt_pkg::DIR_UP;
    end else if (tri_xs < {1'b0, feat.ys}) begin
      sector = feat.y_pos ? jtpt_pkg::DIR_UP : jtpt_pkg::DIR_DOWN;
    end else if (tri_ys < {1'b0, feat.xs}) begin
      sector = feat.x_pos ? jtpt_pkg::DIR_LEFT : jtpt_pkg::DIR_RIGHT;
    end else if (feat.y_pos) begin
      sector = feat.x_pos ? jtpt_pkg::DIR_UP_LEFT : jtpt_pkg::DIR_UP_RIGHT;
    end else begin
      sector = feat.x_pos ? jtpt_pkg::DIR_DOWN_LEFT : jtpt_pkg::DIR_DOWN_RIGHT;
    end
  end

  always_comb begin
    can_load   = !cmd.valid || cmd.ready;
    load       = 1'b0;
    load_stop  = 1'b0;
    load_last  = 1'b0;
    feat_ready = 1'b0;
    if (feat_valid) begin
      if (feat.centered) begin
        if (!motion_active) begin
          feat_ready = 1'b1;
        end else if (can_load) begin
          load       = 1'b1;
          load_stop  = 1'b1;
          load_last  = 1'b1;
          feat_ready = 1'b1;
        end
      end else if (motion_active && !stop_sent) begin
        if (can_load) begin
          load      = 1'b1;
          load_stop = 1'b1;
        end
      end else if (can_load) begin
        load       = 1'b1;
        load_last  = 1'b1;
        feat_ready = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_active    <= 1'b0;
      active_direction <= jtpt_pkg::DIR_UP;
      stop_sent        <= 1'b0;
      cmd.valid        <= 1'b0;
    end else begin
      if (can_load) begin
        cmd.valid <= load;
      end
      if (load && load_stop && !load_last) begin
        stop_sent <= 1'b1;
      end
      if (feat_valid && feat_ready) begin
        stop_sent <= 1'b0;
        if (feat.centered) begin
          motion_active <= 1'b0;
        end else begin
          motion_active    <= 1'b1;
          active_direction <= sector;
        end
      end
    end
    if (load) begin
      cmd.direction <= load_stop ? active_direction : sector;
      cmd.stop_flag <= load_stop;
      cmd.speed     <= load_stop ? jtpt_pkg::StopSpeed : feat.speed;
      cmd.channel   <= load_stop ? jtpt_pkg::ChanStop : jtpt_pkg::ChanStart;
      cmd.last      <= load_last;
    end
  end

endmodule

// File: hdl/joystick_to_pan_tilt_command.sv
// Top level of the joystick to pan/tilt command block.
// Depends on jtpt_pkg, jtpt_if, jtpt_calc and jtpt_seq.
//
//   port  | dir | word contents                                   | handshake
//   ------+-----+-------------------------------------------------+-----------
//   joy   | in  | x_deflection, y_deflection (signed Q1.15)       | valid/ready
//   cmd   | out | direction, stop_flag, speed, channel, last      | valid/ready
//   cfg   | in  | dead_zone (Q0.15 magnitude)                     | valid/ready
//
// Words: a joystick word yields no command word, one, or two when it stops a running
//   motion and starts a new one; the single cmd output register issues one command
//   word per cycle while cmd is ready.
// Path: an accepted joy word passes through the input register, loaded at the accepting
//   edge, then the feature and command registers.
// Reset: rst is synchronous; it clears all valid bits and the motion state, and loads
//   dead_zone with its default of about 0.1.
// Stalls: a stalled cmd holds its word; joy keeps accepting until the input and
//   feature registers are full. cfg is always ready.
module joystick_to_pan_tilt_command #(
  parameter int SPEED_LEVELS = jtpt_pkg::SpeedLevelsDef
) (
  input  logic        clk,
  input  logic        rst,
  jtpt_in_if.sink     joy,
  jtpt_cfg_if.sink    cfg,
  jtpt_out_if.source  cmd
);

  logic [jtpt_pkg::DeadZoneW-1:0] dead_zone;
  logic                           feat_valid;
  logic                           feat_ready;
  jtpt_pkg::feat_t                feat;

  // Dead-zone register: always accept the write.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= jtpt_pkg::DeadZoneRst;
    end else if (cfg.valid) begin
      dead_zone <= cfg.dead_zone;
    end
  end

  // Magnitudes, squares, speed level and the dead-zone test.
  jtpt_calc #(
    .SPEED_LEVELS (SPEED_LEVELS)
  ) u_calc (
    .clk        (clk),
    .rst        (rst),
    .joy        (joy),
    .dead_zone  (dead_zone),
    .feat_valid (feat_valid),
    .feat_ready (feat_ready),
    .feat       (feat)
  );

  // Sector choice, motion state and ordering of stop and start words.
  jtpt_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .feat_valid (feat_valid),
    .feat_ready (feat_ready),
    .feat       (feat),
    .cmd        (cmd)
  );

endmodule

// File: hdl/jtpt_checker.sv
// Port-level checker for the command channel, bound to the top level.
// Depends on jtpt_pkg.
module jtpt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic [2:0]                    cmd_direction,
  input logic                          cmd_stop_flag,
  input logic [jtpt_pkg::SpeedW-1:0]   cmd_speed,
  input logic [jtpt_pkg::ChanW-1:0]    cmd_channel,
  input logic                          cmd_last
);

  // Stop words always go out on the stop channel at the lowest speed.
  a_stop_word: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stop_flag |-> cmd_speed == jtpt_pkg::StopSpeed &&
                                   cmd_channel == jtpt_pkg::ChanStop)
    else $error("stop word with wrong speed or channel");

  // Start words are on the start channel, end their item and never at speed zero.
  a_start_word: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stop_flag |-> cmd_channel == jtpt_pkg::ChanStart && cmd_last &&
                                    cmd_speed != '0)
    else $error("malformed start word");

  // A non-final word is the leading stop, followed at once by its start.
  a_stop_then_start: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && !cmd_last |=> cmd_valid && !cmd_stop_flag)
    else $error("leading stop not followed by start");

  // Hold a stalled word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_direction) &&
                                $stable(cmd_stop_flag) && $stable(cmd_speed) &&
                                $stable(cmd_channel) && $stable(cmd_last))
    else $error("stalled command word changed");

endmodule

bind joystick_to_pan_tilt_command jtpt_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .cmd_direction (cmd.direction),
  .cmd_stop_flag (cmd.stop_flag),
  .cmd_speed     (cmd.speed),
  .cmd_channel   (cmd.channel),
  .cmd_last      (cmd.last)
);

// File: tb/tb_joystick_to_pan_tilt_command.sv
// Self-checking testbench for joystick_to_pan_tilt_command: joystick words in, pan/tilt
// command words out, checked in order against a predictor of the motion state machine.
// Depends on jtpt_pkg, the jtpt interfaces and the block itself.
module tb_joystick_to_pan_tilt_command;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SpeedLevels   = jtpt_pkg::SpeedLevelsDef;
  // Three register stages sit between joy and cmd; settle() waits past them before a
  // dead-zone write so that a centered word with no command is surely gone.
  localparam int SettleCycles  = 8;
  localparam int HoldOffCycles = 300;
  // Limit covers the slowest legal run over ~1400 words plus the hold-off.
  localparam int CycleLimit    = 400000;

  typedef struct packed {
    jtpt_pkg::dir_t              direction;
    logic                        stop_flag;
    logic [jtpt_pkg::SpeedW-1:0] speed;
    logic [jtpt_pkg::ChanW-1:0]  channel;
    logic                        last;
  } command_t;

  logic clk = 1'b0;
  logic rst;

  jtpt_in_if  joy_if ();
  jtpt_cfg_if cfg_if ();
  jtpt_out_if cmd_if ();

  joystick_to_pan_tilt_command #(
    .SPEED_LEVELS(SpeedLevels)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .joy(joy_if),
    .cfg(cfg_if),
    .cmd(cmd_if)
  );

  always #10 clk = ~clk;

  // Predictor state: our own copy of the dead zone and of the motion tracker.
  logic [jtpt_pkg::DeadZoneW-1:0] dead_zone_q;
  logic                           motion_on;
  jtpt_pkg::dir_t                 moving_dir;

  // Command words owed by the block, oldest first.
  command_t pending_cmds[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  // Idling controls: a quiet side never inserts gaps; hold_off_len asks the cmd receiver
  // for one long stall, which it counts out in its own process.
  bit quiet_source   = 1'b0;
  bit quiet_sink     = 1'b0;
  int hold_off_len   = 0;

  logic signed [jtpt_pkg::XyW-1:0] corners [6] = '{-16'sd32768, -16'sd32767, -16'sd1,
                                                   16'sd0, 16'sd1, 16'sd32767};

  // Append one owed command word behind the others.
  function automatic void owe_cmd(command_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Work out the command words that one accepted joystick word causes and advance
  // the motion state. Sector edges are exact: 3*x^2 vs y^2 and 3*y^2 vs x^2.
  function automatic void predict_commands(logic signed [jtpt_pkg::XyW-1:0] x,
                                           logic signed [jtpt_pkg::XyW-1:0] y);
    int             ax, ay, peak, lvl, cap;
    longint         xsq, ysq;
    jtpt_pkg::dir_t heading;
    ax   = (x < 0) ? -int'(x) : int'(x);
    ay   = (y < 0) ? -int'(y) : int'(y);
    peak = (ax > ay) ? ax : ay;

    // Centered: stop only a running motion, otherwise nothing comes out.
    if (ax < int'(dead_zone_q) && ay < int'(dead_zone_q)) begin
      if (motion_on) begin
        owe_cmd('{moving_dir, 1'b1, jtpt_pkg::StopSpeed, jtpt_pkg::ChanStop, 1'b1});
        motion_on = 1'b0;
      end
      return;
    end

    // Speed: floor of levels times the larger magnitude, kept within 1..cap.
    cap = (SpeedLevels < jtpt_pkg::SpeedCapMax) ? SpeedLevels : jtpt_pkg::SpeedCapMax;
    lvl = (SpeedLevels * peak) >>> 15;
    if (lvl < 1) lvl = 1;
    if (lvl > cap) lvl = cap;

    xsq = longint'(x) * longint'(x);
    ysq = longint'(y) * longint'(y);
    if (x == 0 && y == 0) heading = jtpt_pkg::DIR_UP;
    else if (3 * xsq < ysq) heading = (y > 0) ? jtpt_pkg::DIR_UP : jtpt_pkg::DIR_DOWN;
    else if (3 * ysq < xsq) heading = (x > 0) ? jtpt_pkg::DIR_LEFT : jtpt_pkg::DIR_RIGHT;
    else if (y > 0) heading = (x > 0) ? jtpt_pkg::DIR_UP_LEFT : jtpt_pkg::DIR_UP_RIGHT;
    else heading = (x > 0) ? jtpt_pkg::DIR_DOWN_LEFT : jtpt_pkg::DIR_DOWN_RIGHT;

    // A new start always stops the running motion first, naming the old direction.
    if (motion_on) begin
      owe_cmd('{moving_dir, 1'b1, jtpt_pkg::StopSpeed, jtpt_pkg::ChanStop, 1'b0});
    end
    owe_cmd('{heading, 1'b0, jtpt_pkg::SpeedW'(lvl), jtpt_pkg::ChanStart, 1'b1});
    motion_on  = 1'b1;
    moving_dir = heading;
  endfunction

  function automatic logic signed [jtpt_pkg::XyW-1:0] to_q15(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[jtpt_pkg::XyW-1:0];
  endfunction

  // Offer one joystick word after a random gap; predict at the accepting edge.
  // valid stays high afterwards so back-to-back words need no extra edge.
  task automatic send_word(input logic signed [jtpt_pkg::XyW-1:0] x,
                           input logic signed [jtpt_pkg::XyW-1:0] y);
    int unsigned gap;
    gap = quiet_source ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      joy_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    joy_if.valid        <= 1'b1;
    joy_if.x_deflection <= x;
    joy_if.y_deflection <= y;
    do @(posedge clk); while (!(joy_if.valid && joy_if.ready));
    predict_commands(x, y);
  endtask

  // Drop joy valid, wait for every owed command word, then let the pipe empty.
  task automatic settle();
    joy_if.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_dead_zone(input logic [jtpt_pkg::DeadZoneW-1:0] value);
    settle();
    cfg_if.valid     <= 1'b1;
    cfg_if.dead_zone <= value;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    dead_zone_q = value;
  endtask

  // Mix of full-range words, words around the dead zone (these make centered stops
  // frequent), full-scale corners, and words within a few LSBs of a sector edge.
  task automatic send_random_word();
    int                              span, a, b;
    logic signed [jtpt_pkg::XyW-1:0] x, y;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        x = jtpt_pkg::XyW'($urandom);
        y = jtpt_pkg::XyW'($urandom);
      end
      5, 6: begin
        span = int'(dead_zone_q) + 2;
        x = to_q15(int'($urandom_range(0, 2 * span)) - span);
        y = to_q15(int'($urandom_range(0, 2 * span)) - span);
      end
      7: begin
        x = corners[$urandom_range(0, 5)];
        y = corners[$urandom_range(0, 5)];
      end
      default: begin
        // b/a near sqrt(3) puts the word on a 30 or 60 degree edge.
        a = int'($urandom_range(1, 18918));
        b = a * 1732 / 1000 + int'($urandom_range(0, 4)) - 2;
        x = to_q15(a);
        y = to_q15(b);
        if ($urandom_range(0, 1) == 1) begin
          x = to_q15(b);
          y = to_q15(a);
        end
        if ($urandom_range(0, 1) == 1) x = -x;
        if ($urandom_range(0, 1) == 1) y = -y;
      end
    endcase
    send_word(x, y);
  endtask

  // Sectors, extremes and the motion special cases at the reset dead zone.
  task automatic test_directed_cases();
    send_word(16'sd0, 16'sd0);            // centered while idle: nothing
    send_word(16'sd0, 16'sd32767);        // up, first start
    send_word(16'sd0, -16'sd32768);       // stop up, then down at full speed
    send_word(16'sd32767, 16'sd0);        // left (positive x)
    send_word(-16'sd32768, 16'sd0);       // right
    send_word(16'sd20000, 16'sd20000);    // up_left
    send_word(-16'sd20000, 16'sd20000);   // up_right
    send_word(16'sd20000, -16'sd20000);   // down_left
    send_word(-16'sd32768, -16'sd32768);  // down_right, full-scale on both axes
    send_word(16'sd100, -16'sd50);        // centered while moving: one stop
    send_word(16'sd100, 16'sd50);         // centered while idle again
    send_word(16'sd3277, 16'sd0);         // magnitude equal to dead zone is not centered
    send_word(16'sd3276, -16'sd3276);     // just inside the dead zone
    send_word(16'sd10000, 16'sd17320);    // on the 30 degree edge side: up_left
    send_word(16'sd10000, 16'sd17321);    // just past it: up
    send_word(16'sd17320, 16'sd10000);    // on the 60 degree edge side: up_left
    send_word(16'sd17321, 16'sd10000);    // just past it: left
    send_word(-16'sd32767, 16'sd32767);   // up_right at speed 6
    send_word(16'sd1, -16'sd32768);       // down
  endtask

  // Dead zone at zero (nothing centered, even the origin) and at full scale.
  task automatic test_dead_zone_extremes();
    write_dead_zone('0);
    send_word(16'sd0, 16'sd0);
    send_word(16'sd0, 16'sd0);
    send_word(-16'sd1, 16'sd0);
    write_dead_zone('1);
    send_word(16'sd32766, -16'sd32766);
    send_word(16'sd100, -16'sd32767);
    send_word(-16'sd32768, -16'sd32768);
    send_word(16'sd0, 16'sd0);
  endtask

  task automatic test_random_traffic(input logic [jtpt_pkg::DeadZoneW-1:0] zone,
                                     input int count);
    write_dead_zone(zone);
    for (int i = 0; i < count; i++) begin
      // Change the idling mode now and then so some stretches run gap-free.
      if (i % 64 == 0) begin
        quiet_source = ($urandom_range(0, 3) == 0);
        quiet_sink   = ($urandom_range(0, 3) == 0);
      end
      send_random_word();
    end
    quiet_source = 1'b0;
    quiet_sink   = 1'b0;
  endtask

  // Stall cmd for a long stretch while joy words keep coming, so the input and
  // feature registers fill and joy ready drops.
  task automatic test_output_stall();
    hold_off_len = HoldOffCycles;
    quiet_source = 1'b1;
    repeat (48) send_random_word();
    quiet_source = 1'b0;
  endtask

  // cmd receiver: a random stall before each word, or the long hold-off when asked.
  initial begin : drive_cmd_ready
    int unsigned gap;
    cmd_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_len != 0) begin
        gap = hold_off_len;
        hold_off_len = 0;
      end else begin
        gap = quiet_sink ? 0 : $urandom_range(0, 6);
      end
      if (gap != 0) begin
        cmd_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cmd_if.ready <= 1'b1;
      do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
    end
  end

  // Compare every accepted command word with the oldest owed one, field by field.
  always @(posedge clk) begin : check_commands
    command_t want;
    if (!rst && cmd_if.valid && cmd_if.ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command word: expected none, got dir=%0d stop=%0d %s",
                 $time, cmd_if.direction, cmd_if.stop_flag,
                 $sformatf("speed=%0d chan=%0d last=%0d", cmd_if.speed, cmd_if.channel,
                           cmd_if.last));
        mismatch_count++;
      end else begin
        want = pending_cmds.pop_front();
        if (cmd_if.direction !== want.direction) begin
          $display("%0t: direction expected %0d got %0d", $time, want.direction,
                   cmd_if.direction);
          mismatch_count++;
        end
        if (cmd_if.stop_flag !== want.stop_flag) begin
          $display("%0t: stop_flag expected %0d got %0d", $time, want.stop_flag,
                   cmd_if.stop_flag);
          mismatch_count++;
        end
        if (cmd_if.speed !== want.speed) begin
          $display("%0t: speed expected %0d got %0d", $time, want.speed, cmd_if.speed);
          mismatch_count++;
        end
        if (cmd_if.channel !== want.channel) begin
          $display("%0t: channel expected %0d got %0d", $time, want.channel, cmd_if.channel);
          mismatch_count++;
        end
        if (cmd_if.last !== want.last) begin
          $display("%0t: last expected %0d got %0d", $time, want.last, cmd_if.last);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop if the block hangs or loses a command word.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : run_tests
    rst                 <= 1'b1;
    joy_if.valid        <= 1'b0;
    joy_if.x_deflection <= '0;
    joy_if.y_deflection <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.dead_zone    <= jtpt_pkg::DeadZoneRst;
    dead_zone_q = jtpt_pkg::DeadZoneRst;
    motion_on   = 1'b0;
    moving_dir  = jtpt_pkg::DIR_UP;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_dead_zone_extremes();
    test_random_traffic(jtpt_pkg::DeadZoneRst, 300);
    test_output_stall();
    test_random_traffic(jtpt_pkg::DeadZoneW'(1), 250);
    test_random_traffic(jtpt_pkg::DeadZoneW'($urandom_range(2, 32766)), 250);
    test_random_traffic('1, 200);
    test_random_traffic(jtpt_pkg::DeadZoneW'($urandom_range(0, 8000)), 300);

    // Drain whatever is still owed, then give the pipe its latency to go quiet.
    settle();
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
hdl/jtpt_pkg.sv
hdl/jtpt_if.sv
hdl/jtpt_calc.sv
hdl/jtpt_seq.sv
hdl/joystick_to_pan_tilt_command.sv
hdl/jtpt_checker.sv
tb/tb_joystick_to_pan_tilt_command.sv
